### hw/rtl/pidpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pidpd_pkg: PID phase delay controller package
// Shared codes, register indexes and fixed widths.
// ----------------------------------------------------------------------------
package pidpd_pkg;

	// config register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SETPOINT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_MAX = 3'd5;

	// field widths
	localparam int TEMP_W  = 16;
	localparam int GAIN_W  = 8;
	localparam int LIMIT_W = 14;
	localparam int DELAY_W = 8;
	localparam int ERR_W   = TEMP_W + 1;     // setpoint - temperature
	localparam int INTEG_W = LIMIT_W + 1;    // clamped integral, signed
	localparam int SUM_W   = ERR_W + 1;      // integral + error before clamp
	localparam int DIFF_W  = ERR_W + 1;      // error - last error
	localparam int DRV_W   = 28;             // raw drive, holds all three terms

	// reset gains and limits in whole units
	localparam int SETPOINT_RST_WHOLE = 25;
	localparam int LIMIT_RST_WHOLE    = 50;
	localparam logic [GAIN_W-1:0] GAIN_P_RST = 8'd50;
	localparam logic [GAIN_W-1:0] GAIN_I_RST = 8'd10;
	localparam logic [GAIN_W-1:0] GAIN_D_RST = 8'd1;
	localparam logic [DELAY_W-1:0] DELAY_MAX_RST = 8'd200;

	// item commands
	localparam logic CMD_STEP  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	// drive clip codes
	typedef enum logic [1:0] {
		CLIP_NONE = 2'd0,
		CLIP_LOW  = 2'd1,
		CLIP_HIGH = 2'd2
	} clip_t;

endpackage
`default_nettype wire

### hw/rtl/pid_phase_delay_controller_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pid_phase_delay_controller_core: PID heater control to phase delay
// Temperature in, clamped-integral PID drive out as a phase delay.
// ----------------------------------------------------------------------------
// Usage:
//   Item channel (item_valid / item_stall): command, temperature, sample_valid.
//   A step item yields exactly one result; a clear item zeroes the integral
//   and yields nothing. An invalid sample runs the step with temperature 0.
//   Result channel (result_valid / result_stall): fire_delay, drive_clip.
//   Config channel (cfg_valid / cfg_ready): cfg_index selects setpoint,
//   gain_p, gain_i, gain_d, integral_limit, delay_max; ready is always high;
//   unknown indexes are dropped. Write only while the block is idle.
// Timing:
//   Three-register pipeline: input stage, second stage, result register.
//   An item moves from input stage to second stage to result register.
//   One item per clock unless stalled; integral and last error are updated in the
//   input stage, so back-to-back items see each other's state at once.
// Reset: arst_n clears pipeline valids, integral and last error, and loads
//   the config defaults. Stall: a stalled result holds; upper stages keep
//   filling until the pipeline is full, then item_stall is raised.
// ----------------------------------------------------------------------------
module pid_phase_delay_controller_core #(
	parameter int TEMP_FRAC_BITS = 7
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// config write channel
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [pidpd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [pidpd_pkg::CFG_DATA_W-1:0]     cfg_data,
	// item channel
	input  wire logic                                 item_valid,
	output logic                                      item_stall,
	input  wire logic                                 command,
	input  wire logic signed [pidpd_pkg::TEMP_W-1:0]  temperature,
	input  wire logic                                 sample_valid,
	// result channel
	output logic                                      result_valid,
	input  wire logic                                 result_stall,
	output logic [pidpd_pkg::DELAY_W-1:0]             fire_delay,
	output logic [1:0]                                drive_clip
);
	import pidpd_pkg::*;

	// ---------------------------------------------------------------- config
	logic signed [TEMP_W-1:0] setpoint_q;
	logic [GAIN_W-1:0]        gain_p_q;
	logic [GAIN_W-1:0]        gain_i_q;
	logic [GAIN_W-1:0]        gain_d_q;
	logic [LIMIT_W-1:0]       int_limit_q;
	logic [DELAY_W-1:0]       delay_max_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q  <= TEMP_W'(SETPOINT_RST_WHOLE << TEMP_FRAC_BITS);
			gain_p_q    <= GAIN_P_RST;
			gain_i_q    <= GAIN_I_RST;
			gain_d_q    <= GAIN_D_RST;
			int_limit_q <= LIMIT_W'(LIMIT_RST_WHOLE << TEMP_FRAC_BITS);
			delay_max_q <= DELAY_MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SETPOINT:  setpoint_q  <= cfg_data;
				REG_GAIN_P:    gain_p_q    <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I:    gain_i_q    <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D:    gain_d_q    <= cfg_data[GAIN_W-1:0];
				REG_INT_LIMIT: int_limit_q <= cfg_data[LIMIT_W-1:0];
				REG_DELAY_MAX: delay_max_q <= cfg_data[DELAY_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------- flow control
	logic vld_s1;
	logic vld_s2;
	logic res_vld_q;
	logic adv_out;
	logic adv_s2;
	logic adv_s1;

	assign adv_out    = !res_vld_q || !result_stall;
	assign adv_s2     = !vld_s2 || adv_out;
	assign adv_s1     = !vld_s1 || adv_s2;
	assign item_stall = !adv_s1;

	// ------------------------------------------------------- input stage
	logic                     cmd_s1;
	logic signed [TEMP_W-1:0] temp_s1;
	logic                     svld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv_s1) begin
			vld_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && item_valid) begin
			cmd_s1  <= command;
			temp_s1 <= temperature;
			svld_s1 <= sample_valid;
		end
	end

	// error, clamped integral, derivative term; state updated here
	logic signed [INTEG_W-1:0] integral_q;
	logic signed [ERR_W-1:0]   last_err_q;
	logic signed [TEMP_W-1:0]  temp_eff;
	logic signed [ERR_W-1:0]   err;
	logic signed [SUM_W-1:0]   sum_raw;
	logic signed [SUM_W-1:0]   lim_pos;
	logic signed [SUM_W-1:0]   lim_neg;
	logic signed [SUM_W-1:0]   sum_clamp;
	logic signed [DIFF_W-1:0]  diff;

	assign temp_eff = svld_s1 ? temp_s1 : '0;
	assign err      = {setpoint_q[TEMP_W-1], setpoint_q} - {temp_eff[TEMP_W-1], temp_eff};
	assign sum_raw  = {{(SUM_W-INTEG_W){integral_q[INTEG_W-1]}}, integral_q}
	                + {err[ERR_W-1], err};
	assign lim_pos  = {{(SUM_W-LIMIT_W){1'b0}}, int_limit_q};
	assign lim_neg  = -lim_pos;
	assign diff     = {err[ERR_W-1], err} - {last_err_q[ERR_W-1], last_err_q};

	always_comb begin
		priority if (sum_raw > lim_pos) begin
			sum_clamp = lim_pos;
		end else if (sum_raw < lim_neg) begin
			sum_clamp = lim_neg;
		end else begin
			sum_clamp = sum_raw;
		end
	end

	logic step_go;
	logic clear_go;

	assign step_go  = vld_s1 && adv_s2 && (cmd_s1 == CMD_STEP);
	assign clear_go = vld_s1 && adv_s2 && (cmd_s1 == CMD_CLEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= '0;
			last_err_q <= '0;
		end else if (clear_go) begin
			integral_q <= '0;
		end else if (step_go) begin
			integral_q <= sum_clamp[INTEG_W-1:0];
			last_err_q <= err;
		end
	end

	// ------------------------------------------------------- second stage
	logic signed [ERR_W-1:0]   err_s2;
	logic signed [INTEG_W-1:0] integ_s2;
	logic signed [DIFF_W-1:0]  diff_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s2) begin
			vld_s2 <= vld_s1 && (cmd_s1 == CMD_STEP);
		end
	end

	always_ff @(posedge clk) begin
		if (step_go) begin
			err_s2   <= err;
			integ_s2 <= sum_clamp[INTEG_W-1:0];
			diff_s2  <= diff;
		end
	end

	// drive = kp*err + ki*integral + kd*diff, then classify
	logic signed [GAIN_W:0]               gp_ext;
	logic signed [GAIN_W:0]               gi_ext;
	logic signed [GAIN_W:0]               gd_ext;
	logic signed [GAIN_W+ERR_W:0]         prod_p;
	logic signed [GAIN_W+INTEG_W:0]       prod_i;
	logic signed [GAIN_W+DIFF_W:0]        prod_d;
	logic signed [DRV_W-1:0]              drive;
	logic [DRV_W-1:0]                     drive_u;
	logic [DRV_W-1:0]                     whole_max;
	logic [DRV_W-1:0]                     drive_whole;
	logic [DELAY_W-1:0]                   delay_nxt;
	clip_t                                clip_nxt;

	assign gp_ext = {1'b0, gain_p_q};
	assign gi_ext = {1'b0, gain_i_q};
	assign gd_ext = {1'b0, gain_d_q};
	assign prod_p = gp_ext * err_s2;
	assign prod_i = gi_ext * integ_s2;
	assign prod_d = gd_ext * diff_s2;
	assign drive  = DRV_W'(prod_p) + DRV_W'(prod_i) + DRV_W'(prod_d);

	assign drive_u     = drive;
	assign whole_max   = DRV_W'(delay_max_q) << TEMP_FRAC_BITS;
	assign drive_whole = drive_u >> TEMP_FRAC_BITS;

	always_comb begin
		priority if (drive[DRV_W-1]) begin
			delay_nxt = delay_max_q;
			clip_nxt  = CLIP_LOW;
		end else if (drive_u > whole_max) begin
			delay_nxt = '0;
			clip_nxt  = CLIP_HIGH;
		end else begin
			// drive_whole <= delay_max here, no underflow
			delay_nxt = delay_max_q - drive_whole[DELAY_W-1:0];
			clip_nxt  = CLIP_NONE;
		end
	end

	// ------------------------------------------------------- result register
	logic [DELAY_W-1:0] delay_q;
	clip_t              clip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (adv_out) begin
			res_vld_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && vld_s2) begin
			delay_q <= delay_nxt;
			clip_q  <= clip_nxt;
		end
	end

	assign result_valid = res_vld_q;
	assign fire_delay   = delay_q;
	assign drive_clip   = clip_q;

	// ------------------------------------------------------- assertions
	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		clear_go |=> (integral_q == '0))
		else $error("integral not cleared after clear item");

	a_clip_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (drive_clip == CLIP_NONE || drive_clip == CLIP_LOW
		|| drive_clip == CLIP_HIGH))
		else $error("undefined drive_clip code");

	a_high_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && drive_clip == CLIP_HIGH) |-> (fire_delay == '0))
		else $error("high clip with nonzero delay");

	a_low_max: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && drive_clip == CLIP_LOW) |-> (fire_delay == delay_max_q))
		else $error("low clip without maximum delay");

endmodule
`default_nettype wire
